// ----- hw/rtl/ase_pkg.sv -----
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types, sizes and codes for the array set engine.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int FIELD_W  = 5;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Search chain passed from cell to cell.
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] pos;
    } ase_chain_t;

    // Update strobes broadcast to every cell.
    typedef struct packed {
        logic remove_en;
        logic add_en;
    } ase_ctrl_t;

    // Fit a count or position into the 5-bit result field.
    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] wide;
        begin
            wide = {{FIELD_W{1'b0}}, v};
            return wide[FIELD_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/ase_cell.sv -----
// ----------------------------------------------------------------------------
// ase_cell
// One table slot: holds an entry, compares it with the key, passes the
// search chain on, and takes its neighbor's entry on a shift-down.
// ----------------------------------------------------------------------------
module ase_cell (
    input  logic                          clk,
    input  logic [ase_pkg::IDX_W-1:0]     idx,
    input  logic [ase_pkg::CNT_W-1:0]     fill,
    input  logic [ase_pkg::KEY_W-1:0]     key,
    input  ase_pkg::ase_ctrl_t            ctrl,
    input  ase_pkg::ase_chain_t           chain_in,
    input  logic [ase_pkg::KEY_W-1:0]     neighbor,
    output ase_pkg::ase_chain_t           chain_out,
    output logic [ase_pkg::KEY_W-1:0]     entry
);
    import ase_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [CNT_W-1:0] idx_ext;
    logic             occupied;
    logic             match;

    assign idx_ext  = CNT_W'(idx);
    assign occupied = idx_ext < fill;
    assign match    = occupied && (entry_reg == key);

    always_comb
    begin
        chain_out.hit = chain_in.hit | match;
        chain_out.pos = chain_in.pos | (match ? (idx_ext + CNT_W'(1)) : '0);
    end

    // Remove: this cell and every later one take the neighbor's word. Add: the cell at the fill count takes the key.
    always_ff @(posedge clk)
    begin
        if (ctrl.remove_en && (chain_in.hit || match))
        begin
            entry_reg <= neighbor;
        end
        else if (ctrl.add_en && (idx_ext == fill))
        begin
            entry_reg <= key;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/array_set_engine_core.sv -----
// ----------------------------------------------------------------------------
// array_set_engine_core
// Set of distinct 32-bit values in insertion order: lookup, add, remove.
// ----------------------------------------------------------------------------
// Response valid is registered: it rises in the cycle after the request is accepted.
// Throughput: 1 request per cycle while the response side does not stall; the compare-and-shift pass through the
//   cell row completes in the accept cycle.
// Reset: rst_n clears the fill count and the response valid; entries are
//   not cleared, only cells below the fill count are ever compared.
// ----------------------------------------------------------------------------
module array_set_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    cmd,
    input  logic signed [31:0]            value,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [4:0]                    position,
    output logic [1:0]                    status,
    output logic [4:0]                    count
);
    import ase_pkg::*;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               rsp_valid_reg;
    logic [FIELD_W-1:0] position_reg;
    logic [1:0]         status_reg;
    logic [FIELD_W-1:0] count_reg;

    logic               accept;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [CNT_W-1:0]   hit_pos;
    logic               not_full;
    status_t            status_next;
    ase_ctrl_t          ctrl;

    // Search chain and entry taps of the cell row.
    ase_chain_t         chain [0:CAPACITY];
    logic [KEY_W-1:0]   entries [0:CAPACITY-1];

    // A request is taken whenever the response register is free or
    // draining this cycle, so a response that drains this cycle never blocks the slot.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign key       = value;

    // ------------------------------------------------------------------
    // Cell row: chain[0] starts empty, each cell ORs in its own match.
    // The top cell shifts in its own word; that slot is freed anyway.
    // ------------------------------------------------------------------
    assign chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] nbr;
        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr = entries[i];
        end
        else
        begin : g_mid
            assign nbr = entries[i+1];
        end

        ase_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .fill      (fill_reg),
            .key       (key),
            .ctrl      (ctrl),
            .chain_in  (chain[i]),
            .neighbor  (nbr),
            .chain_out (chain[i+1]),
            .entry     (entries[i])
        );
    end

    assign hit      = chain[CAPACITY].hit;
    assign hit_pos  = chain[CAPACITY].pos;
    assign not_full = fill_reg < CNT_W'(CAPACITY);

    // ------------------------------------------------------------------
    // Command decode: strobes to the cells, status and new fill count.
    // Unused command code behaves as a lookup.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl        = '0;
        fill_next   = fill_reg;
        status_next = hit ? ST_DONE : ST_ABSENT;
        case (cmd)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status_next = ST_PRESENT;
                end
                else if (!not_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next  = ST_DONE;
                    ctrl.add_en  = accept;
                    fill_next    = fill_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    status_next    = ST_DONE;
                    ctrl.remove_en = accept;
                    fill_next      = fill_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            default:
            begin
                status_next = hit ? ST_DONE : ST_ABSENT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Fill count and response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            position_reg <= to_field(hit_pos);
            status_reg   <= status_next;
            count_reg    <= to_field(fill_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign position  = position_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        hit == (hit_pos != '0))
        else $error("search chain hit and position disagree");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid_reg)
        else $error("request stalled with empty response slot");

    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp_valid_reg && count_reg == to_field(fill_reg)))
        else $error("response missing or count mismatch after accept");
`endif

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for array_set_engine_core.
// Sends lookup, add and remove words with random gaps on both channels. A
// shadow copy of the set predicts position, status and count for each word,
// and the responses are checked in order. A short directed table comes first,
// covering empty, full, extreme values and the spare command. The random
// part then swings between filling and draining the set.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ase_pkg::*;

    // cmd 3 has no enum member; the block treats it as a lookup
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 14;
    localparam int KEY_POOL     = 24;     // more keys than cells, so both hits and misses
    localparam int PHASE_LEN    = 120;    // words per fill / drain phase
    localparam int QUIET_LO     = 500;    // words in [QUIET_LO, QUIET_HI) run with no gaps
    localparam int QUIET_HI     = 650;
    localparam int HOLD_AT      = 300;    // response count that starts the long hold-off
    localparam int HOLD_LEN     = 80;

    typedef struct packed {
        logic [4:0] position;
        status_t    status;
        logic [4:0] count;
    } set_reply_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic        typed;     // reply below is the expectation, else predicted
        set_reply_t  reply;
    } table_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         cmd       = CMD_LOOKUP;
    logic signed [31:0] value     = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [4:0]         position;
    logic [1:0]         status;
    logic [4:0]         count;

    // Shadow of the set, updated as each word is accepted
    logic [31:0] shadow_cells [CAPACITY];
    int          shadow_fill;
    logic [31:0] key_pool [KEY_POOL];

    set_reply_t  reply_q [$];
    int          fail_count  = 0;
    int          words_seen  = 0;
    int          cycle_count = 0;
    logic        hold        = 1'b0;

    array_set_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .position  (position),
        .status    (status),
        .count     (count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: search the occupied cells, then add / remove in place.
    // Position is the match before the operation; count is after it.
    // ------------------------------------------------------------------
    function automatic set_reply_t apply_request(input logic [1:0] op, input logic [31:0] key);
        set_reply_t r;
        int         hit;
        hit = 0;
        for (int i = 0; i < shadow_fill; i++)
        begin
            if (hit == 0 && shadow_cells[i] == key)
                hit = i + 1;
        end
        r.position = hit[4:0];
        case (op)
            CMD_ADD:
            begin
                if (hit != 0)
                    r.status = ST_PRESENT;
                else if (shadow_fill >= CAPACITY)
                    r.status = ST_FULL;     // absent but no room: refused
                else
                begin
                    shadow_cells[shadow_fill] = key;
                    shadow_fill++;
                    r.status = ST_DONE;
                end
            end
            CMD_REMOVE:
            begin
                if (hit == 0)
                    r.status = ST_ABSENT;
                else
                begin
                    // close the gap, keeping insertion order
                    for (int i = hit - 1; i < shadow_fill - 1; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_fill--;
                    r.status = ST_DONE;
                end
            end
            default:    // lookup, and the spare code
                r.status = (hit != 0) ? ST_DONE : ST_ABSENT;
        endcase
        r.count = shadow_fill[4:0];
        return r;
    endfunction

    // Random word: alternating phases lean toward adds, then toward removes,
    // so the set swings between empty and full. Keys come mostly from the
    // current members and a small pool, the rest fully random.
    task automatic pick_word(input int n, output logic [1:0] op, output logic [31:0] key);
        int roll;
        int add_pct;
        int sel;
        add_pct = ((n / PHASE_LEN) % 2 == 0) ? 60 : 20;
        roll    = $urandom_range(99);
        if (roll < 3)
            op = CMD_SPARE;
        else if (roll < 25)
            op = CMD_LOOKUP;
        else if (roll < 25 + add_pct)
            op = CMD_ADD;
        else
            op = CMD_REMOVE;
        sel = $urandom_range(99);
        if (sel < 40 && shadow_fill > 0)
            key = shadow_cells[$urandom_range(shadow_fill - 1)];
        else if (sel < 70)
            key = key_pool[$urandom_range(KEY_POOL - 1)];
        else
            key = $urandom;
    endtask

    // Offer one word, with an optional random gap first; returns on the
    // edge where it is taken. valid stays high from word to word when no gap is drawn.
    task automatic send_word(input logic [1:0] op, input logic [31:0] key, input bit quiet);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= op;
        value     <= key;
        do @(posedge clk); while (req_stall);
    endtask

    // ------------------------------------------------------------------
    // Request side: directed table, random words, then drain and verdict
    // ------------------------------------------------------------------
    initial
    begin
        table_row_t  rows [$];
        table_row_t  row;
        logic [1:0]  op;
        logic [31:0] key;

        shadow_fill = 0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_cells[i] = '0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // empty set: misses everywhere
        rows.push_back(table_row_t'{CMD_LOOKUP, 32'h0000_0000, 1'b1, '{5'd0, ST_ABSENT, 5'd0}});
        rows.push_back(table_row_t'{CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, '{5'd0, ST_ABSENT, 5'd0}});
        // extremes in, duplicate add, hits by lookup and by the spare code
        rows.push_back(table_row_t'{CMD_ADD,    32'h8000_0000, 1'b1, '{5'd0, ST_DONE,    5'd1}});
        rows.push_back(table_row_t'{CMD_ADD,    32'h7FFF_FFFF, 1'b1, '{5'd0, ST_DONE,    5'd2}});
        rows.push_back(table_row_t'{CMD_ADD,    32'h8000_0000, 1'b1, '{5'd1, ST_PRESENT, 5'd2}});
        rows.push_back(table_row_t'{CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{5'd2, ST_DONE,    5'd2}});
        rows.push_back(table_row_t'{CMD_SPARE,  32'h8000_0000, 1'b1, '{5'd1, ST_DONE,    5'd2}});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0000_0000, 1'b1, '{5'd0, ST_DONE,    5'd3}});
        rows.push_back(table_row_t'{CMD_ADD,    32'hFFFF_FFFF, 1'b1, '{5'd0, ST_DONE,    5'd4}});
        // fill the remaining cells
        rows.push_back(table_row_t'{CMD_ADD,    32'h0000_0001, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0000_0002, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0000_0004, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0000_0008, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0001_0000, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h0100_0000, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h4000_0000, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'hAAAA_AAAA, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h5555_5555, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'hFFFF_FFFE, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h8000_0001, 1'b0, '0});
        rows.push_back(table_row_t'{CMD_ADD,    32'h7FFF_FFFE, 1'b0, '0});
        // full: new key refused, present key still found
        rows.push_back(table_row_t'{CMD_ADD,    32'h1234_5678, 1'b1, '{5'd0, ST_FULL,    5'd16}});
        rows.push_back(table_row_t'{CMD_ADD,    32'h8000_0000, 1'b1, '{5'd1, ST_PRESENT, 5'd16}});
        // remove from the middle, then check the shift and the last cell
        rows.push_back(table_row_t'{CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, '{5'd2, ST_DONE,    5'd15}});
        rows.push_back(table_row_t'{CMD_LOOKUP, 32'h0000_0000, 1'b1, '{5'd2, ST_DONE,    5'd15}});
        rows.push_back(table_row_t'{CMD_REMOVE, 32'h7FFF_FFFE, 1'b1, '{5'd15, ST_DONE,   5'd14}});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_word(row.op, row.key, 1'b0);
            if (row.typed)
            begin
                void'(apply_request(row.op, row.key));
                reply_q.push_back(row.reply);
            end
            else
                reply_q.push_back(apply_request(row.op, row.key));
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick_word(n, op, key);
            send_word(op, key, n >= QUIET_LO && n < QUIET_HI);
            reply_q.push_back(apply_request(op, key));
        end
        req_valid <= 1'b0;

        while (reply_q.size() != 0)
            @(posedge clk);
        // spare edges catch any stray response
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("[array_set_engine_core] OK");
        else
            $display("[array_set_engine_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: check against the oldest expectation, drive stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                words_seen++;
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected word: position %0d status %0d count %0d",
                             $time, position, status, count);
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (position !== want.position)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, position);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %s actual %0d",
                                 $time, want.status.name(), status);
                        fail_count++;
                    end
                    if (count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, count);
                        fail_count++;
                    end
                end
            end

            if (hold)
                rsp_stall <= 1'b1;
            else if (words_seen >= QUIET_LO && words_seen < QUIET_HI)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Long hold-off on the response side; the sender keeps offering, so the
    // output register fills and the request channel must stall.
    initial
    begin
        wait (words_seen >= HOLD_AT);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time, reply_q.size());
            $display("[array_set_engine_core] ERROR");
            $finish;
        end
    end

endmodule

// ----- array_set_engine_core.f -----
hw/rtl/ase_pkg.sv
hw/rtl/ase_cell.sv
hw/rtl/array_set_engine_core.sv
verif/testbench.sv
